/* sv/breath_phase_detector_assert.svh */
// Assertion macros for the breath phase detector.
// Used inside modules that have aclk and aresetn in scope; no other dependency.
`ifndef BREATH_PHASE_DETECTOR_ASSERT_SVH
`define BREATH_PHASE_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bpd_pkg.sv */
// Types and constants for the breath phase detector.
// No dependencies; imported by breath_phase_detector and its testbench.
`timescale 1ns / 1ps

package bpd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_IN   = 2'd1,
        PH_OUT  = 2'd2,
        PH_HOLD = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_PREP,
        ST_DIV,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        REG_INTAKE    = 2'd0,
        REG_OUTFLOW   = 2'd1,
        REG_TIMEOUT   = 2'd2,
        REG_STABILITY = 2'd3
    } reg_idx_t;

    localparam int DELTA_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int MEAN_W   = 32;
    localparam int TOTAL_W  = 16;
    localparam int THR_W    = 16;
    localparam int STAB_W   = 15;
    localparam int ADDR_W   = 4;
    localparam int DIV_STEPS = MEAN_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    localparam logic signed [THR_W-1:0] INTAKE_RESET  = -16'sd32;
    localparam logic signed [THR_W-1:0] OUTFLOW_RESET = 16'sd32;
    localparam logic [THR_W-1:0]        TIMEOUT_RESET = 16'd3000;
    localparam logic [STAB_W-1:0]       STAB_RESET    = 15'd16;

endpackage

/* sv/breath_phase_detector.sv */
// An accepted item passes through classification and then emission; a sample that counts a
// breath also passes through divider preparation, the divide and the fold into the mean.
// No new item is taken until the result is loaded into the output register, which waits while
// a result is still held; the 32-step bit-serial divider folds the cycle time into the mean.
// Reset (aresetn, synchronous): phase idle, last-change time, count and mean zero, registers at defaults.
// Timing and classification registers (bpd_pkg) and assertion macros (assert header).
`timescale 1ns / 1ps
`include "breath_phase_detector_assert.svh"

module breath_phase_detector
    import bpd_pkg::*;
#(
    parameter int TIME_BITS  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // pressure_delta[15:0], now_ms[47:16]
    input  logic                 s_tuser,   // func
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata    // phase[1:0], breath_total[17:2],
                                            // mean_cycle_ms[49:18], breath_counted[50]
);

    // Configuration registers
    logic signed [THR_W-1:0] intake_thr_reg;
    logic signed [THR_W-1:0] outflow_thr_reg;
    logic [THR_W-1:0]        timeout_reg;
    logic [STAB_W-1:0]       stability_reg;
    logic                    cfg_we;
    reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intake_thr_reg  <= INTAKE_RESET;
            outflow_thr_reg <= OUTFLOW_RESET;
            timeout_reg     <= TIMEOUT_RESET;
            stability_reg   <= STAB_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_INTAKE:    intake_thr_reg  <= pwdata[THR_W-1:0];
                REG_OUTFLOW:   outflow_thr_reg <= pwdata[THR_W-1:0];
                REG_TIMEOUT:   timeout_reg     <= pwdata[THR_W-1:0];
                REG_STABILITY: stability_reg   <= pwdata[STAB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INTAKE:    prdata = {16'd0, intake_thr_reg};
            REG_OUTFLOW:   prdata = {16'd0, outflow_thr_reg};
            REG_TIMEOUT:   prdata = {16'd0, timeout_reg};
            REG_STABILITY: prdata = {17'd0, stability_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Control and datapath state
    state_t                  state_reg, state_next;
    phase_t                  phase_reg;
    logic [TIME_BITS-1:0]    last_change_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [MEAN_W-1:0]       mean_reg;
    logic                    m_tvalid_reg;

    logic                    func_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic [TIME_BITS-1:0]    elapsed_reg;
    logic                    counted_reg;
    logic [MEAN_W-1:0]       cyc_reg;
    logic                    sub_reg;
    logic [MEAN_W-1:0]       dvd_reg;
    logic [COUNT_BITS-1:0]   rem_reg;
    logic [STEP_W-1:0]       step_reg;

    phase_t                  out_phase_reg;
    logic [TOTAL_W-1:0]      out_total_reg;
    logic [MEAN_W-1:0]       out_mean_reg;
    logic                    out_counted_reg;

    // Timestamp taken modulo 2^TIME_BITS
    logic [63:0]             now_wide;
    logic [TIME_BITS-1:0]    now_in;
    assign now_wide = {32'd0, s_tdata[DELTA_W +: STAMP_W]};
    assign now_in   = now_wide[TIME_BITS-1:0];

    // Classification
    logic [DELTA_W:0]        delta_x;
    logic [DELTA_W:0]        mag;
    logic                    is_in, is_out, quiet, stable;
    phase_t                  phase_new;
    logic                    changed;
    logic                    count_breath;
    logic [63:0]             el_wide;
    logic [MEAN_W-1:0]       cyc_sat;

    assign delta_x = {delta_reg[DELTA_W-1], delta_reg};
    assign mag     = delta_reg[DELTA_W-1] ? ((DELTA_W+1)'(0) - delta_x) : delta_x;
    assign is_in   = delta_reg < intake_thr_reg;
    assign is_out  = delta_reg > outflow_thr_reg;
    assign quiet   = elapsed_reg > TIME_BITS'(timeout_reg);
    assign stable  = mag < (DELTA_W+1)'(stability_reg);

    always_comb begin
        if (is_in) begin
            phase_new = PH_IN;
        end else if (is_out) begin
            phase_new = PH_OUT;
        end else if (quiet && stable) begin
            phase_new = PH_HOLD;
        end else begin
            phase_new = PH_IDLE;
        end
    end

    assign changed      = phase_new != phase_reg;
    assign count_breath = changed && (phase_reg == PH_OUT) && (phase_new == PH_IN)
                          && !(&count_reg);

    // A cycle longer than the mean can hold is clipped to its largest value.
    assign el_wide = 64'(elapsed_reg);
    assign cyc_sat = (|el_wide[63:MEAN_W]) ? '1 : el_wide[MEAN_W-1:0];

    // Restoring division, one quotient bit per cycle; quotient shifts into dvd_reg.
    logic [COUNT_BITS:0]     trial;
    logic                    trial_ok;
    logic [COUNT_BITS:0]     trial_diff;
    logic                    rem_nz;
    assign trial      = {rem_reg, dvd_reg[MEAN_W-1]};
    assign trial_ok   = trial >= {1'b0, count_reg};
    assign trial_diff = trial - {1'b0, count_reg};
    assign rem_nz     = |rem_reg;

    // Handshake and sequencing
    logic out_free;
    logic out_load;
    logic div_last;

    assign out_free = !m_tvalid_reg || m_tready;
    assign div_last = step_reg == STEP_W'(DIV_STEPS - 1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_CLASS;
            ST_CLASS: begin
                if (!func_reg && count_breath) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_PREP:  state_next = ST_DIV;
            ST_DIV:   if (div_last) state_next = ST_FOLD;
            ST_FOLD:  state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = state_reg == ST_IDLE;
        out_load = (state_reg == ST_EMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_IDLE;
            last_change_reg <= '0;
            count_reg       <= '0;
            mean_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == ST_CLASS) begin
                if (func_reg) begin
                    count_reg <= '0;
                    mean_reg  <= '0;
                end else begin
                    phase_reg <= phase_new;
                    if (changed) last_change_reg <= now_reg;
                    if (count_breath) count_reg <= count_reg + 1'b1;
                end
            end
            if (state_reg == ST_FOLD) begin
                if (sub_reg) begin
                    mean_reg <= mean_reg - dvd_reg - MEAN_W'(rem_nz);
                end else begin
                    mean_reg <= mean_reg + dvd_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg    <= s_tuser;
            delta_reg   <= s_tdata[DELTA_W-1:0];
            now_reg     <= now_in;
            elapsed_reg <= now_in - last_change_reg;
        end
        if (state_reg == ST_CLASS) begin
            counted_reg <= !func_reg && count_breath;
            cyc_reg     <= cyc_sat;
        end
        if (state_reg == ST_PREP) begin
            sub_reg  <= cyc_reg < mean_reg;
            dvd_reg  <= (cyc_reg < mean_reg) ? (mean_reg - cyc_reg) : (cyc_reg - mean_reg);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == ST_DIV) begin
            dvd_reg  <= {dvd_reg[MEAN_W-2:0], trial_ok};
            rem_reg  <= trial_ok ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            step_reg <= step_reg + 1'b1;
        end
        if (out_load) begin
            out_phase_reg   <= phase_reg;
            out_total_reg   <= TOTAL_W'(count_reg);
            out_mean_reg    <= mean_reg;
            out_counted_reg <= counted_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_counted_reg, out_mean_reg, out_total_reg, out_phase_reg};

    // Checks
    `BPD_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "accepted item while busy")
    `BPD_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIV, count_reg != '0, "division by zero count")
    `BPD_ASSERT_NOW(a_fold_no_underflow, (state_reg == ST_FOLD) && sub_reg, (33'(dvd_reg) + 33'(rem_nz)) <= 33'(mean_reg), "mean would underflow")
    `BPD_ASSERT_NOW(a_counted_in, m_tvalid_reg && out_counted_reg, out_phase_reg == PH_IN, "breath counted outside in phase")

endmodule

/* tb/breath_phase_detector_test.sv */
// Self-checking testbench for breath_phase_detector: stream driver and monitor with a
// built-in phase, breath count and running-mean predictor, plus APB register writes.
// Depends on bpd_pkg and the breath_phase_detector RTL only.
`timescale 1ns / 1ps

module breath_phase_detector_test;
    import bpd_pkg::*;

    localparam int LIMIT_CYCLES    = 10_000_000;
    localparam int SETTLE_CYCLES   = 50;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 30;

    typedef struct packed {
        logic               func;
        logic [DELTA_W-1:0] delta;
        logic [STAMP_W-1:0] stamp;
    } sample_t;

    typedef struct packed {
        phase_t             phase;
        logic [TOTAL_W-1:0] total;
        logic [MEAN_W-1:0]  mean;
        logic               counted;
    } reading_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata  = '0;   // pressure_delta[15:0], now_ms[47:16]
    logic               s_tuser  = 1'b0; // func
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [55:0]        m_tdata;         // phase[1:0], breath_total[17:2],
                                         // mean_cycle_ms[49:18], breath_counted[50]

    // Predictor copy of the registers and of the block's state.
    logic signed [THR_W-1:0] thr_in      = INTAKE_RESET;
    logic signed [THR_W-1:0] thr_out     = OUTFLOW_RESET;
    logic [THR_W-1:0]        quiet_ms    = TIMEOUT_RESET;
    logic [STAB_W-1:0]       stable_mag  = STAB_RESET;
    phase_t                  cur_phase   = PH_IDLE;
    logic [STAMP_W-1:0]      last_change = '0;
    logic [TOTAL_W-1:0]      breaths     = '0;
    logic [MEAN_W-1:0]       mean_ms     = '0;

    sample_t  sample_queue[$];
    reading_t awaited[$];
    sample_t  cur_item;
    bit       offering = 1'b0;
    bit       s_fire   = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_left     = 0;

    phase_t             gen_target = PH_IDLE;
    logic [STAMP_W-1:0] gen_stamp  = '0;

    int     errors       = 0;
    int     items_taken  = 0;
    int     resets_taken = 0;
    int     results_seen = 0;
    int     breaths_seen = 0;
    int     full_blocked = 0;
    int     reg_writes   = 0;
    longint cycles_run   = 0;

    breath_phase_detector dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles_run++;
        if (cycles_run >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycles_run, awaited.size());
            $display("** breath_phase_detector: FAILED **");
            $finish;
        end
    end

    // Advances the predicted state by one item and returns the reading it should give.
    function automatic reading_t classify_breath(input sample_t smp);
        reading_t           r;
        phase_t             nxt;
        int                 d;
        int                 magnitude;
        logic [STAMP_W-1:0] elapsed;
        longint unsigned    n;
        longint unsigned    cyc;
        longint unsigned    avg;
        r.counted = 1'b0;
        if (smp.func) begin
            breaths = '0;
            mean_ms = '0;
        end else begin
            d = $signed(smp.delta);
            magnitude = (d < 0) ? -d : d;
            elapsed = smp.stamp - last_change;
            if (d < thr_in) begin
                nxt = PH_IN;
            end else if (d > thr_out) begin
                nxt = PH_OUT;
            end else if (elapsed > quiet_ms && magnitude < int'(stable_mag)) begin
                nxt = PH_HOLD;
            end else begin
                nxt = PH_IDLE;
            end
            if (nxt != cur_phase) begin
                if (cur_phase == PH_OUT && nxt == PH_IN) begin
                    if (breaths != '1) begin
                        breaths = breaths + 1'b1;
                        n   = breaths;
                        cyc = elapsed;
                        avg = mean_ms;
                        // Rounds the new mean down in both directions.
                        if (cyc >= avg) begin
                            avg = avg + (cyc - avg) / n;
                        end else begin
                            avg = avg - (avg - cyc + n - 1) / n;
                        end
                        mean_ms = avg[MEAN_W-1:0];
                        r.counted = 1'b1;
                    end else begin
                        full_blocked++;
                    end
                end
                last_change = smp.stamp;
            end
            cur_phase = nxt;
        end
        r.phase = cur_phase;
        r.total = breaths;
        r.mean  = mean_ms;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch at result %0d: %s is %0d, expected %0d",
                     results_seen, what, got, want);
    endtask

    // Input side: an item is taken at the edge where tvalid and tready are both high.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            awaited.push_back(classify_breath(cur_item));
            items_taken++;
            if (cur_item.func)
                resets_taken++;
            s_fire = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (s_fire) begin
            s_fire   = 1'b0;
            offering = 1'b0;
        end
        if (!offering) begin
            if (aresetn && sample_queue.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                cur_item = sample_queue.pop_front();
                offering = 1'b1;
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_item.stamp, cur_item.delta};
                s_tuser  <= cur_item.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: a long hold-off takes precedence over the random stalls.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (awaited.size() == 0) begin
                flag_mismatch("item with nothing awaited, phase", m_tdata[1:0], 0);
            end else begin
                want = awaited.pop_front();
                if (want.counted)
                    breaths_seen++;
                if (m_tdata[1:0] !== want.phase)
                    flag_mismatch("phase", m_tdata[1:0], want.phase);
                if (m_tdata[17:2] !== want.total)
                    flag_mismatch("breath_total", m_tdata[17:2], want.total);
                if (m_tdata[49:18] !== want.mean)
                    flag_mismatch("mean_cycle_ms", m_tdata[49:18], want.mean);
                if (m_tdata[50] !== want.counted)
                    flag_mismatch("breath_counted", m_tdata[50], want.counted);
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input int value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INTAKE:    thr_in     = 16'(value);
            REG_OUTFLOW:   thr_out    = 16'(value);
            REG_TIMEOUT:   quiet_ms   = 16'(value);
            REG_STABILITY: stable_mag = 15'(value);
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all(input int t_in, input int t_out, input int quiet,
                             input int stab);
        write_reg(REG_INTAKE, t_in);
        write_reg(REG_OUTFLOW, t_out);
        write_reg(REG_TIMEOUT, quiet);
        write_reg(REG_STABILITY, stab);
    endtask

    task automatic shuffle_config();
        int t_in;
        int t_out;
        t_in  = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                         : -int'($urandom_range(600));
        t_out = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                         : int'($urandom_range(600));
        write_all(t_in, t_out,
                  ($urandom_range(1) == 0) ? $urandom_range(5000) : $urandom_range(65535),
                  ($urandom_range(1) == 0) ? $urandom_range(200) : $urandom_range(32767));
    endtask

    // Waits until every item has gone in and every result has come out.
    task automatic settle();
        do @(negedge aclk);
        while (sample_queue.size() != 0 || offering || awaited.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic add_sample(input logic f, input int d, input logic [STAMP_W-1:0] t);
        sample_queue.push_back({f, 16'(d), t});
    endtask

    // A delta that falls in the wanted band under the current thresholds where it can.
    function automatic int pick_delta(input phase_t want);
        int t_in;
        int t_out;
        int span;
        int off;
        int lim;
        t_in  = thr_in;
        t_out = thr_out;
        case (want)
            PH_IN: begin
                if (t_in > -32768) begin
                    span = t_in + 32767;
                    off  = ($urandom_range(3) == 0) ? $urandom_range(span)
                                                    : $urandom_range(span < 64 ? span : 64);
                    return t_in - 1 - off;
                end
            end
            PH_OUT: begin
                if (t_out < 32767) begin
                    span = 32766 - t_out;
                    off  = ($urandom_range(3) == 0) ? $urandom_range(span)
                                                    : $urandom_range(span < 64 ? span : 64);
                    return t_out + 1 + off;
                end
            end
            default: begin
                lim = int'(stable_mag) + 2;
                off = int'($urandom_range(2 * lim)) - lim;
                if (off > 32767)
                    off = 32767;
                if (off < -32768)
                    off = -32768;
                return off;
            end
        endcase
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Mostly well-formed breathing with random timing; some session resets and noise.
    task automatic queue_breathing(input int count);
        int r;
        int step;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 6) begin
                add_sample(1'b1, $urandom_range(65535), $urandom());
            end else if (r < 14) begin
                add_sample(1'b0, $urandom_range(65535), $urandom());
            end else begin
                r = $urandom_range(99);
                if (r < 5) begin
                    step = 0;
                end else if (r < 10) begin
                    step = $urandom();
                end else if (r < 25) begin
                    step = int'(quiet_ms) + int'($urandom_range(2)) - 1;
                end else begin
                    step = $urandom_range(4000, 1);
                end
                gen_stamp = gen_stamp + 32'(step);
                r = $urandom_range(99);
                if (gen_target == PH_IN) begin
                    if (r < 70) gen_target = PH_OUT;
                    else gen_target = PH_IDLE;
                end else if (gen_target == PH_OUT) begin
                    if (r < 75) gen_target = PH_IN;
                    else gen_target = PH_IDLE;
                end else begin
                    if (r < 50) gen_target = PH_IN;
                    else gen_target = PH_OUT;
                end
                add_sample(1'b0, pick_delta(gen_target), gen_stamp);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset thresholds: boundaries, hold timing, wrapped time and session resets.
        add_sample(1'b0, 0, 32'd0);
        add_sample(1'b0, 32767, 32'd100);
        add_sample(1'b0, -32768, 32'd1100);
        add_sample(1'b0, 33, 32'd2100);
        add_sample(1'b0, -33, 32'd4100);
        add_sample(1'b0, 40, 32'd4600);
        add_sample(1'b0, -40, 32'd4700);
        add_sample(1'b0, -32, 32'd4800);
        add_sample(1'b0, 32, 32'd4900);
        add_sample(1'b0, 15, 32'd7800);
        add_sample(1'b0, -15, 32'd7801);
        add_sample(1'b0, 16, 32'd9000);
        add_sample(1'b0, 0, 32'd20000);
        add_sample(1'b1, -1234, 32'hDEAD_BEEF);
        add_sample(1'b0, 500, 32'hFFFF_FF00);
        add_sample(1'b0, -500, 32'h0000_0100);
        add_sample(1'b0, 500, 32'h0000_1000);
        add_sample(1'b0, -500, 32'h0000_0800);
        add_sample(1'b1, 32767, 32'd0);
        add_sample(1'b0, 0, 32'hFFFF_FFFF);
        add_sample(1'b0, -32768, 32'd0);
        settle();

        shuffle_config();
        queue_breathing(90);
        settle();

        shuffle_config();
        send_idle_pct = 56;
        queue_breathing(90);
        settle();

        // Receiver holds off while the sender keeps offering, so the input backs up.
        shuffle_config();
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        stall_left     = HOLD_OFF_CYCLES;
        queue_breathing(90);
        settle();

        // Sender pauses half way until the block has delivered everything.
        shuffle_config();
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        queue_breathing(45);
        settle();
        queue_breathing(45);
        settle();

        // Widest band for idle and hold: the most negative delta is never stable.
        write_all(-32768, 32767, 0, 32767);
        gen_stamp = gen_stamp + 32'd10;
        add_sample(1'b0, -32768, gen_stamp);
        add_sample(1'b0, 32767, gen_stamp + 32'd1);
        add_sample(1'b0, -32767, gen_stamp + 32'd2);
        queue_breathing(45);
        settle();

        write_all(32767, -32768, 65535, 0);
        send_idle_pct  = 56;
        recv_stall_pct = 0;
        queue_breathing(45);
        settle();

        $display("Run took %0d items (%0d session resets) under %0d register writes,",
                 items_taken, resets_taken, reg_writes);
        $display("checked %0d results with %0d breaths counted and %0d refused at a full count.",
                 results_seen, breaths_seen, full_blocked);
        if (errors == 0) begin
            $display("** breath_phase_detector: PASSED **");
        end else begin
            $display("** breath_phase_detector: FAILED **");
        end
        $finish;
    end

endmodule
